/* sv/greedy_box_suppression_defines.svh */
// ---------------------------------------------------------------------------
// Greedy box suppression: assertion macros
// Shared property forms for the checker; they expect clk_i and rst_ni in scope.
// ---------------------------------------------------------------------------
`ifndef GREEDY_BOX_SUPPRESSION_DEFINES_SVH
`define GREEDY_BOX_SUPPRESSION_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define GBS_ASSERT_IMPL(name, pre, post, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication, checked outside reset
`define GBS_ASSERT_NEXT(name, pre, post, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

/* sv/gbs_pkg.sv */
// ---------------------------------------------------------------------------
// Greedy box suppression: package
// Sizes, stored entry layout, register indexes, controller states and the
// command and status groups between controller and datapath.
// ---------------------------------------------------------------------------
`default_nettype none

package gbs_pkg;

  localparam int MAX_BOXES  = 256;
  localparam int COORD_BITS = 12;
  localparam int IDX_W      = $clog2(MAX_BOXES);
  localparam int CNT_W      = IDX_W + 1;
  localparam int SCORE_W    = 16;
  localparam int POS_W      = 8;
  localparam int THR_W      = 16;
  localparam int LIM_W      = 7;
  localparam int RESULT_LIMIT = 64;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;
  localparam int EXT_W      = COORD_BITS + 1;    // inclusive extent
  localparam int PROD_W     = 2 * EXT_W;         // area or intersection
  localparam int UNI_W      = PROD_W + 1;        // union
  localparam int CMP_W      = THR_W + UNI_W;     // cross-multiplied compare

  localparam logic [THR_W-1:0] IOU_RESET  = THR_W'(19661);
  localparam logic [LIM_W-1:0] KEEP_RESET = LIM_W'(64);

  typedef struct packed {
    logic [COORD_BITS-1:0] left;
    logic [COORD_BITS-1:0] top;
    logic [COORD_BITS-1:0] right;
    logic [COORD_BITS-1:0] bottom;
    logic [SCORE_W-1:0]    score;
    logic [POS_W-1:0]      src;
  } entry_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IOU_THRESHOLD = 1'b0,
    CFG_KEEP_LIMIT    = 1'b1
  } cfg_reg_e;

  typedef enum logic [3:0] {
    S_IDLE, S_INS_CHK, S_INS_CMP, S_END_CHK,
    S_SUP_I, S_SUP_A, S_SUP_J, S_SUP_DRAIN,
    S_EM_SCAN, S_EM_LOAD, S_EM_FLUSH, S_CLEAR
  } state_e;

  typedef struct packed {
    logic in_ready;
    logic accept;
    logic rd_prev;
    logic shift;
    logic put_new;
    logic sup_skip;
    logic rd_a;
    logic load_a;
    logic issue_j;
    logic row_done;
    logic em_skip;
    logic em_rd;
    logic em_load;
    logic em_flush;
    logic clear;
  } cmd_t;

  typedef struct packed {
    logic in_valid;
    logic full;
    logic pos_zero;
    logic rd_less;
    logic cur_last;
    logic i_end;
    logic i_sup;
    logic j_end;
    logic pipe_busy;
    logic k_end;
    logic k_sup;
    logic n_full;
    logic h_valid;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

/* sv/gbs_if.sv */
// ---------------------------------------------------------------------------
// Greedy box suppression: channel interfaces
// Box input channel and kept-box result channel, valid/ready handshake.
// ---------------------------------------------------------------------------
`default_nettype none

interface gbs_box_if import gbs_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] box_left;
  logic [COORD_BITS-1:0] box_top;
  logic [COORD_BITS-1:0] box_right;
  logic [COORD_BITS-1:0] box_bottom;
  logic [SCORE_W-1:0]    box_score;
  logic                  last_box;

  modport source (output valid, box_left, box_top, box_right, box_bottom, box_score,
                  last_box, input ready);
  modport sink (input valid, box_left, box_top, box_right, box_bottom, box_score,
                last_box, output ready);
endinterface

interface gbs_kept_if import gbs_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] kept_left;
  logic [COORD_BITS-1:0] kept_top;
  logic [COORD_BITS-1:0] kept_right;
  logic [COORD_BITS-1:0] kept_bottom;
  logic [SCORE_W-1:0]    kept_score;
  logic [POS_W-1:0]      source_position;
  logic                  overflowed;
  logic                  last_result;

  modport source (output valid, kept_left, kept_top, kept_right, kept_bottom, kept_score,
                  source_position, overflowed, last_result, input ready);
  modport sink (input valid, kept_left, kept_top, kept_right, kept_bottom, kept_score,
                source_position, overflowed, last_result, output ready);
endinterface

`default_nettype wire

/* sv/gbs_ctrl.sv */
// ---------------------------------------------------------------------------
// Greedy box suppression: controller
// Sequences insertion, the suppression sweep and result emission.
// ---------------------------------------------------------------------------
`default_nettype none

module gbs_ctrl import gbs_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  sts_t   sts_i,
  output cmd_t   cmd_o
);

  state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        cmd_o.in_ready = 1'b1;
        if (sts_i.in_valid) begin
          cmd_o.accept = 1'b1;
          state_d = sts_i.full ? S_END_CHK : S_INS_CHK;
        end
      end
      S_INS_CHK: begin
        if (sts_i.pos_zero) begin
          cmd_o.put_new = 1'b1;
          state_d = S_END_CHK;
        end else begin
          cmd_o.rd_prev = 1'b1;
          state_d = S_INS_CMP;
        end
      end
      S_INS_CMP: begin
        if (sts_i.rd_less) begin
          cmd_o.shift = 1'b1;
          state_d = S_INS_CHK;
        end else begin
          cmd_o.put_new = 1'b1;
          state_d = S_END_CHK;
        end
      end
      S_END_CHK: begin
        state_d = sts_i.cur_last ? S_SUP_I : S_IDLE;
      end
      S_SUP_I: begin
        if (sts_i.i_end) begin
          state_d = S_EM_SCAN;
        end else if (sts_i.i_sup) begin
          cmd_o.sup_skip = 1'b1;
        end else begin
          cmd_o.rd_a = 1'b1;
          state_d = S_SUP_A;
        end
      end
      S_SUP_A: begin
        cmd_o.load_a = 1'b1;
        state_d = S_SUP_J;
      end
      S_SUP_J: begin
        if (sts_i.j_end) begin
          state_d = S_SUP_DRAIN;
        end else begin
          cmd_o.issue_j = 1'b1;
        end
      end
      S_SUP_DRAIN: begin
        if (!sts_i.pipe_busy) begin
          cmd_o.row_done = 1'b1;
          state_d = S_SUP_I;
        end
      end
      S_EM_SCAN: begin
        if (sts_i.k_end || sts_i.n_full) begin
          state_d = sts_i.h_valid ? S_EM_FLUSH : S_CLEAR;
        end else if (sts_i.k_sup) begin
          cmd_o.em_skip = 1'b1;
        end else begin
          cmd_o.em_rd = 1'b1;
          state_d = S_EM_LOAD;
        end
      end
      S_EM_LOAD: begin
        if (!sts_i.h_valid || sts_i.out_free) begin
          cmd_o.em_load = 1'b1;
          state_d = S_EM_SCAN;
        end
      end
      S_EM_FLUSH: begin
        if (sts_i.out_free) begin
          cmd_o.em_flush = 1'b1;
          state_d = S_CLEAR;
        end
      end
      S_CLEAR: begin
        cmd_o.clear = 1'b1;
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

/* sv/gbs_dp.sv */
// ---------------------------------------------------------------------------
// Greedy box suppression: datapath
// Ranked box memory, counters, overlap pipeline, suppression marks, result
// holding stage, output register and configuration registers.
// ---------------------------------------------------------------------------
`default_nettype none

module gbs_dp import gbs_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  cmd_t                  cmd_i,
  output sts_t                  sts_o,
  gbs_box_if.sink               box_i,
  gbs_kept_if.source            kept_o
);

  localparam logic [EXT_W-1:0]   EXT_ONE = EXT_W'(1);
  localparam logic [EXT_W:0]     IW_ONE  = (EXT_W + 1)'(1);
  localparam logic [LIM_W-1:0]   LIM_MAX = LIM_W'(RESULT_LIMIT);
  localparam logic [CNT_W-1:0]   CNT_MAX = CNT_W'(MAX_BOXES);

  // Configuration and set state
  logic [THR_W-1:0]     iou_q;
  logic [LIM_W-1:0]     keep_q;
  logic [CNT_W-1:0]     count_q, pos_q, i_q, j_q, k_q;
  logic [LIM_W-1:0]     n_q;
  logic                 ovf_q, last_q;
  logic [MAX_BOXES-1:0] sup_q;
  entry_t               new_q, rd_q, a_q, h_q;
  logic                 h_vld_q;
  logic [PROD_W-1:0]    area_a_q;

  // Ranked box memory
  entry_t               mem [MAX_BOXES];
  logic                 mem_we, mem_re;
  logic [IDX_W-1:0]     mem_waddr, mem_raddr;
  entry_t               mem_wdata;
  logic [CNT_W-1:0]     pos_m1;

  // Overlap pipeline
  logic                 v0_q, v1_q, v2_q, v3_q, v4_q;
  logic [IDX_W-1:0]     t0_q, t1_q, t2_q, t3_q, t4_q;
  logic [EXT_W:0]       iw_q, ih_q;
  logic [EXT_W-1:0]     wb_q, hb_q;
  logic                 ovl2_q, ovl3_q, ovl4_q;
  logic [PROD_W-1:0]    inter2_q, areab2_q, inter3_q, inter4_q;
  logic [UNI_W-1:0]     uni3_q;
  logic [CMP_W-1:0]     prod4_q;
  logic [COORD_BITS-1:0] x1, y1, x2, y2;
  logic                 hit;

  // Output register
  logic                 out_vld_q, out_last_q, out_ovf_q;
  entry_t               out_q;
  logic                 out_free, out_load;
  logic [LIM_W-1:0]     lim;

  assign pos_m1    = pos_q - CNT_W'(1);
  assign mem_we    = cmd_i.shift | cmd_i.put_new;
  assign mem_waddr = pos_q[IDX_W-1:0];
  assign mem_wdata = cmd_i.shift ? rd_q : new_q;
  assign mem_re    = cmd_i.rd_prev | cmd_i.rd_a | cmd_i.issue_j | cmd_i.em_rd;

  // Pick the read address for the active step
  always_comb begin
    mem_raddr = k_q[IDX_W-1:0];
    if (cmd_i.rd_prev) begin
      mem_raddr = pos_m1[IDX_W-1:0];
    end else if (cmd_i.rd_a) begin
      mem_raddr = i_q[IDX_W-1:0];
    end else if (cmd_i.issue_j) begin
      mem_raddr = j_q[IDX_W-1:0];
    end
  end

  // Memory write and registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_q <= mem[mem_raddr];
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iou_q  <= IOU_RESET;
      keep_q <= KEEP_RESET;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        CFG_IOU_THRESHOLD: iou_q  <= cfg_data_i[THR_W-1:0];
        CFG_KEEP_LIMIT:    keep_q <= cfg_data_i[LIM_W-1:0];
        default: ;
      endcase
    end
  end

  // Latch the incoming box
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      new_q.left   <= box_i.box_left;
      new_q.top    <= box_i.box_top;
      new_q.right  <= box_i.box_right;
      new_q.bottom <= box_i.box_bottom;
      new_q.score  <= box_i.box_score;
      new_q.src    <= count_q[POS_W-1:0];
    end
  end

  // Counters, flags and suppression marks
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      pos_q   <= '0;
      i_q     <= '0;
      j_q     <= '0;
      k_q     <= '0;
      n_q     <= '0;
      ovf_q   <= 1'b0;
      last_q  <= 1'b0;
      sup_q   <= '0;
    end else begin
      if (cmd_i.accept) begin
        pos_q  <= count_q;
        last_q <= box_i.last_box;
        if (count_q == CNT_MAX) begin
          ovf_q <= 1'b1;
        end
      end
      if (cmd_i.shift) begin
        pos_q <= pos_m1;
      end
      if (cmd_i.put_new) begin
        count_q <= count_q + CNT_W'(1);
      end
      if (cmd_i.sup_skip || cmd_i.row_done) begin
        i_q <= i_q + CNT_W'(1);
      end
      if (cmd_i.load_a) begin
        j_q <= i_q + CNT_W'(1);
      end
      if (cmd_i.issue_j) begin
        j_q <= j_q + CNT_W'(1);
      end
      if (cmd_i.em_skip || cmd_i.em_rd) begin
        k_q <= k_q + CNT_W'(1);
      end
      if (cmd_i.em_load) begin
        n_q <= n_q + LIM_W'(1);
      end
      if (hit) begin
        sup_q[t4_q] <= 1'b1;
      end
      if (cmd_i.clear) begin
        count_q <= '0;
        i_q     <= '0;
        k_q     <= '0;
        n_q     <= '0;
        ovf_q   <= 1'b0;
        last_q  <= 1'b0;
        sup_q   <= '0;
      end
    end
  end

  // Hold the reference box of the current row and its area
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_a) begin
      a_q      <= rd_q;
      area_a_q <= (EXT_W'({1'b0, rd_q.right}) - EXT_W'({1'b0, rd_q.left}) + EXT_ONE)
                * (EXT_W'({1'b0, rd_q.bottom}) - EXT_W'({1'b0, rd_q.top}) + EXT_ONE);
    end
  end

  // Intersection corners of the reference box and the candidate
  assign x1 = (a_q.left   > rd_q.left)   ? a_q.left   : rd_q.left;
  assign y1 = (a_q.top    > rd_q.top)    ? a_q.top    : rd_q.top;
  assign x2 = (a_q.right  < rd_q.right)  ? a_q.right  : rd_q.right;
  assign y2 = (a_q.bottom < rd_q.bottom) ? a_q.bottom : rd_q.bottom;

  // Overlap pipeline valid bits and tags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      v0_q <= cmd_i.issue_j;
      v1_q <= v0_q;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  // Overlap pipeline payload: extents, products, union, scaled threshold
  always_ff @(posedge clk_i) begin
    t0_q     <= j_q[IDX_W-1:0];
    t1_q     <= t0_q;
    iw_q     <= {2'b00, x2} - {2'b00, x1} + IW_ONE;
    ih_q     <= {2'b00, y2} - {2'b00, y1} + IW_ONE;
    wb_q     <= EXT_W'({1'b0, rd_q.right})  - EXT_W'({1'b0, rd_q.left}) + EXT_ONE;
    hb_q     <= EXT_W'({1'b0, rd_q.bottom}) - EXT_W'({1'b0, rd_q.top})  + EXT_ONE;
    t2_q     <= t1_q;
    ovl2_q   <= !iw_q[EXT_W] && (iw_q != '0) && !ih_q[EXT_W] && (ih_q != '0);
    inter2_q <= iw_q[EXT_W-1:0] * ih_q[EXT_W-1:0];
    areab2_q <= wb_q * hb_q;
    t3_q     <= t2_q;
    ovl3_q   <= ovl2_q;
    inter3_q <= inter2_q;
    uni3_q   <= {1'b0, area_a_q} + {1'b0, areab2_q} - {1'b0, inter2_q};
    t4_q     <= t3_q;
    ovl4_q   <= ovl3_q;
    inter4_q <= inter3_q;
    prod4_q  <= {{UNI_W{1'b0}}, iou_q} * {{THR_W{1'b0}}, uni3_q};
  end

  // Suppress the candidate when overlap exceeds the threshold
  assign hit = v4_q && ovl4_q && ({1'b0, inter4_q, {THR_W{1'b0}}} > prod4_q);

  // Result holding stage and output register
  assign out_free = !out_vld_q || kept_o.ready;
  assign out_load = (cmd_i.em_load && h_vld_q) || cmd_i.em_flush;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h_vld_q   <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (cmd_i.em_load) begin
        h_vld_q <= 1'b1;
      end else if (cmd_i.em_flush) begin
        h_vld_q <= 1'b0;
      end
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (kept_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.em_load) begin
      h_q <= rd_q;
    end
    if (out_load) begin
      out_q      <= h_q;
      out_last_q <= cmd_i.em_flush;
      out_ovf_q  <= ovf_q;
    end
  end

  assign lim = (keep_q > LIM_MAX) ? LIM_MAX : keep_q;

  assign kept_o.valid           = out_vld_q;
  assign kept_o.kept_left       = out_q.left;
  assign kept_o.kept_top        = out_q.top;
  assign kept_o.kept_right      = out_q.right;
  assign kept_o.kept_bottom     = out_q.bottom;
  assign kept_o.kept_score      = out_q.score;
  assign kept_o.source_position = out_q.src;
  assign kept_o.overflowed      = out_ovf_q;
  assign kept_o.last_result     = out_last_q;
  assign box_i.ready            = cmd_i.in_ready;

  // Status to the controller
  assign sts_o.in_valid  = box_i.valid;
  assign sts_o.full      = (count_q == CNT_MAX);
  assign sts_o.pos_zero  = (pos_q == '0);
  assign sts_o.rd_less   = (rd_q.score < new_q.score);
  assign sts_o.cur_last  = last_q;
  assign sts_o.i_end     = (i_q == count_q);
  assign sts_o.i_sup     = sup_q[i_q[IDX_W-1:0]];
  assign sts_o.j_end     = (j_q == count_q);
  assign sts_o.pipe_busy = v0_q | v1_q | v2_q | v3_q | v4_q;
  assign sts_o.k_end     = (k_q == count_q);
  assign sts_o.k_sup     = sup_q[k_q[IDX_W-1:0]];
  assign sts_o.n_full    = (n_q == lim);
  assign sts_o.h_valid   = h_vld_q;
  assign sts_o.out_free  = out_free;

endmodule

`default_nettype wire

/* sv/greedy_box_suppression.sv */
// ---------------------------------------------------------------------------
// Greedy box suppression: top level
// Loads a set of scored boxes, ranks them by score, suppresses overlapping
// lower-ranked boxes by intersection over union and emits the survivors.
// ---------------------------------------------------------------------------
// Usage:
//   box_i takes one box per transfer; last_box closes the set. kept_o gives
//   the survivors in score order (ties in arrival order), up to keep_limit,
//   with last_result on the final one. A set with no result gives nothing.
//   Configuration is written through cfg_we_i / cfg_idx_i / cfg_data_i
//   between sets.
// Operation:
//   A box is ranked by insertion into one memory with a write port and a
//   registered read port: it moves past every stored box of lower score,
//   and a box that arrives when the set is full is dropped. On the
//   last box the suppression sweep reads one candidate per cycle through a
//   five-stage overlap pipeline, comparing each unsuppressed box with every
//   lower-ranked box and passing over suppressed ones. Emission scans the
//   ranked boxes in order, passes over suppressed ones and waits while the
//   receiver does not take a result.
// Reset and stall:
//   Reset empties the set and restores the registers to 19661 and 64; the
//   memory needs no clearing. A result stays on kept_o until taken; the
//   sweep-out waits, and box_i stays low until the final result of the set
//   is in the output register.
`default_nettype none

module greedy_box_suppression import gbs_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  gbs_box_if.sink               box_i,
  gbs_kept_if.source            kept_o
);

  cmd_t cmd;
  sts_t sts;

  // Sequencer
  gbs_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  // Storage and arithmetic
  gbs_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .box_i      (box_i),
    .kept_o     (kept_o)
  );

endmodule

`default_nettype wire

/* sv/gbs_checker.sv */
// ---------------------------------------------------------------------------
// Greedy box suppression: port checker
// Watches the channel ports of the top level over time.
// ---------------------------------------------------------------------------
`default_nettype none
`include "greedy_box_suppression_defines.svh"

module gbs_checker import gbs_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_i,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input logic [SCORE_W-1:0] out_score_i,
  input logic               out_last_i
);

  // Hold a stalled result
  `GBS_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i, "result dropped while stalled")
  `GBS_ASSERT_NEXT(a_out_stable, out_valid_i && !out_ready_i, $stable(out_score_i) && $stable(out_last_i), "result changed while stalled")

  // Drop ready after each box transfer while it is ranked
  `GBS_ASSERT_NEXT(a_busy_after_take, in_valid_i && in_ready_i, !in_ready_i, "box taken while ranking")

  // No new box while a set is still being sent
  `GBS_ASSERT_IMPL(a_no_take_mid_set, out_valid_i && !out_last_i, !in_ready_i, "box input open mid set")

endmodule

bind greedy_box_suppression gbs_checker u_gbs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (box_i.valid),
  .in_ready_i  (box_i.ready),
  .out_valid_i (kept_o.valid),
  .out_ready_i (kept_o.ready),
  .out_score_i (kept_o.kept_score),
  .out_last_i  (kept_o.last_result)
);

`default_nettype wire
